>>> sv/worst_fit_block_allocator_defines.svh
// Assertion helpers for the allocator control module.
// Each expects clk and rst in scope.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define WFBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfba check failed");

// Next-cycle implication.
`define WFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfba check failed");

`endif

>>> sv/wfba_pkg.sv
package wfba_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int AW           = $clog2(POOL_BYTES);
  localparam int FIELD_W      = 12;
  // Working width for offset and size sums; room for cur + header + size.
  localparam int CW           = ((AW > FIELD_W) ? AW : FIELD_W) + 2;

  typedef logic [AW-1:0]      addr_t;
  typedef logic [CW-1:0]      calc_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam calc_t HDR_C  = calc_t'(HEADER_BYTES);
  localparam calc_t POOL_C = calc_t'(POOL_BYTES);

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // One header table entry.
  typedef struct packed {
    logic  start;
    logic  free;
    addr_t size;
  } entry_t;

  localparam entry_t INIT_ENTRY = '{start: 1'b1, free: 1'b1,
                                    size: addr_t'(POOL_BYTES - HEADER_BYTES)};

  // Table access from the sequencer.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } tbl_req_t;

  typedef struct packed {
    status_t status;
    field_t  grant;
  } result_t;

endpackage

>>> sv/wfba_table.sv
module wfba_table (
  input  logic                clk,
  input  wfba_pkg::tbl_req_t  req,
  output wfba_pkg::entry_t    rd_data
);
  import wfba_pkg::*;

  entry_t mem [POOL_BYTES];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

>>> sv/wfba_ctrl.sv
module wfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wfba_pkg::cmd_t     in_cmd,
  input  wfba_pkg::field_t   in_req,
  input  wfba_pkg::field_t   in_off,
  input  wfba_pkg::entry_t   rd_data,
  output wfba_pkg::tbl_req_t tbl,
  input  logic               slot_free,
  output logic               res_valid,
  output wfba_pkg::result_t  res
);
  import wfba_pkg::*;
  `include "worst_fit_block_allocator_defines.svh"

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WALK, S_DECIDE, S_SPLIT, S_MARK, S_FCHK, S_RESP
  } state_t;

  state_t  state, state_next;
  addr_t   clr_cnt, clr_cnt_next;
  addr_t   cur, cur_next;
  addr_t   best, best_next;
  addr_t   best_size, best_size_next;
  logic    found, found_next;
  field_t  req, req_next;
  addr_t   mark_size, mark_size_next;
  result_t res_next;

  calc_t   step_sum;
  calc_t   free_hdr;
  calc_t   rem;
  calc_t   split_at;
  logic    cand;

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    cur_next       = cur;
    best_next      = best;
    best_size_next = best_size;
    found_next     = found;
    req_next       = req;
    mark_size_next = mark_size;
    res_next       = res;
    tbl            = '{we: 1'b0, waddr: cur, wdata: '0, raddr: cur};
    in_ready       = (state == S_IDLE);
    res_valid      = (state == S_RESP) && slot_free;

    step_sum = calc_t'(cur) + HDR_C + calc_t'(rd_data.size);
    free_hdr = calc_t'(in_off) - HDR_C;
    rem      = calc_t'(best_size) - calc_t'(req);
    split_at = calc_t'(best) + HDR_C + calc_t'(req);
    cand     = rd_data.free && (calc_t'(rd_data.size) >= calc_t'(req)) &&
               (rd_data.size > best_size);

    case (state)
      S_CLEAR: begin
        // Sweep the table once; entry zero becomes the whole-pool free block.
        tbl.we    = 1'b1;
        tbl.waddr = clr_cnt;
        tbl.wdata = (clr_cnt == '0) ? INIT_ENTRY : '0;
        clr_cnt_next = clr_cnt + addr_t'(1);
        if (clr_cnt == addr_t'(POOL_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_ALLOC) begin
            req_next = in_req;
            if (in_req == '0) begin
              res_next   = '{status: ST_ZERO, grant: '0};
              state_next = S_RESP;
            end else begin
              cur_next       = '0;
              tbl.raddr      = '0;
              best_next      = '0;
              best_size_next = '0;
              found_next     = 1'b0;
              state_next     = S_WALK;
            end
          end else if (in_off == '0) begin
            res_next   = '{status: ST_DONE, grant: '0};
            state_next = S_RESP;
          end else if ((calc_t'(in_off) < HDR_C) || (free_hdr >= POOL_C)) begin
            res_next   = '{status: ST_BADADDR, grant: '0};
            state_next = S_RESP;
          end else begin
            cur_next   = free_hdr[AW-1:0];
            tbl.raddr  = free_hdr[AW-1:0];
            state_next = S_FCHK;
          end
        end
      end
      S_WALK: begin
        // rd_data holds the header at cur; fetch the next header meanwhile.
        if (!rd_data.start) begin
          state_next = S_DECIDE;
        end else begin
          if (cand) begin
            best_next      = cur;
            best_size_next = rd_data.size;
            found_next     = 1'b1;
          end
          if (step_sum >= POOL_C) begin
            state_next = S_DECIDE;
          end else begin
            cur_next  = step_sum[AW-1:0];
            tbl.raddr = step_sum[AW-1:0];
          end
        end
      end
      S_DECIDE: begin
        if (!found) begin
          res_next   = '{status: ST_NOFIT, grant: '0};
          state_next = S_RESP;
        end else if ((rem >= HDR_C + calc_t'(1)) && (split_at < POOL_C)) begin
          cur_next       = split_at[AW-1:0];
          mark_size_next = addr_t'(req);
          state_next     = S_SPLIT;
        end else begin
          mark_size_next = best_size;
          state_next     = S_MARK;
        end
      end
      S_SPLIT: begin
        // New free block carved from the leftover.
        tbl.we     = 1'b1;
        tbl.waddr  = cur;
        tbl.wdata  = '{start: 1'b1, free: 1'b1, size: addr_t'(rem - HDR_C)};
        state_next = S_MARK;
      end
      S_MARK: begin
        tbl.we     = 1'b1;
        tbl.waddr  = best;
        tbl.wdata  = '{start: 1'b1, free: 1'b0, size: mark_size};
        res_next   = '{status: ST_DONE,
                       grant: field_t'(calc_t'(best) + HDR_C)};
        state_next = S_RESP;
      end
      S_FCHK: begin
        if (!rd_data.start) begin
          res_next = '{status: ST_BADADDR, grant: '0};
        end else begin
          tbl.we    = 1'b1;
          tbl.waddr = cur;
          tbl.wdata = '{start: 1'b1, free: 1'b1, size: rd_data.size};
          res_next  = '{status: ST_DONE, grant: '0};
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
    cur       <= cur_next;
    best      <= best_next;
    best_size <= best_size_next;
    found     <= found_next;
    req       <= req_next;
    mark_size <= mark_size_next;
    res       <= res_next;
  end

  `WFBA_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !tbl.we)
  `WFBA_ASSERT_NEXT(a_split_then_mark, state == S_SPLIT, state == S_MARK)
  `WFBA_ASSERT_NOW(a_fail_null_grant, res_valid && (res.status != ST_DONE), res.grant == '0)
  `WFBA_ASSERT_NEXT(a_resp_hold, (state == S_RESP) && !slot_free, (state == S_RESP) && $stable(res))

endmodule

>>> sv/worst_fit_block_allocator.sv
// Channel  | Dir | Fields (low bit up)                         | Handshake
// s_axis   | in  | tuser: cmd; tdata: req_size, data_offset    | tvalid/tready
// m_axis   | out | tuser: status; tdata: grant_offset, zeros   | tvalid/tready
//
// Allocate: take the item, walk the block headers in order on the table read
// port, decide, write back (an optional split, then the grant mark) and post
// the result; at most 240 blocks fit the pool.
// Free: read, write, post; zero size, null and offsets below a header go straight to the post.
// After rst the header table is swept one entry a cycle, with s_axis_tready low.
// Take the next item while the last result waits in the output register; a new
// result holds only while that register is full and m_axis_tready is low.
module worst_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] req_size, [23:12] data_offset
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] grant_offset, [15:12] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import wfba_pkg::*;

  tbl_req_t tbl;
  entry_t   rd_data;
  logic     slot_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  // Output slot is free when empty or being drained this cycle.
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  wfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (cmd_t'(s_axis_tuser)),
    .in_req    (s_axis_tdata[FIELD_W-1:0]),
    .in_off    (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .rd_data   (rd_data),
    .tbl       (tbl),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  wfba_table u_table (
    .clk     (clk),
    .req     (tbl),
    .rd_data (rd_data)
  );

  // Output register: load a finished result, hold it until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'b0000, out_res.grant};
  assign m_axis_tuser = out_res.status;

endmodule

>>> sim/tb_worst_fit_block_allocator.sv
`timescale 1ns / 100ps

module tb_worst_fit_block_allocator;
  import wfba_pkg::*;

  // Stop the run here even if the block hangs.
  localparam int unsigned LIMIT_CYCLES = 1_600_000;
  localparam int unsigned RANDOM_ITEMS = 1376;
  // Trailing wait after the last reply.
  localparam int unsigned DRAIN_CYCLES = 300;

  // One row of the directed plan. Rows with known set carry a reply that
  // can be read off the pool layout by hand; the others use the predictor.
  typedef struct packed {
    cmd_t    cmd;
    field_t  req;
    field_t  off;
    logic    known;
    status_t want_status;
    field_t  want_grant;
  } probe_t;

  localparam int PLAN_LEN = 24;
  localparam probe_t PLAN [PLAN_LEN] = '{
    // null free, with every req bit set
    '{CMD_FREE,  12'd4095, 12'd0,    1'b1, ST_DONE,    12'd0},
    // zero-size allocate, with every offset bit set
    '{CMD_ALLOC, 12'd0,    12'd4095, 1'b1, ST_ZERO,    12'd0},
    // larger than the whole pool
    '{CMD_ALLOC, 12'd4095, 12'd0,    1'b1, ST_NOFIT,   12'd0},
    '{CMD_ALLOC, 12'd4081, 12'd0,    1'b1, ST_NOFIT,   12'd0},
    // addresses that are no block
    '{CMD_FREE,  12'd0,    12'd4095, 1'b1, ST_BADADDR, 12'd0},
    '{CMD_FREE,  12'd0,    12'd1,    1'b1, ST_BADADDR, 12'd0},
    '{CMD_FREE,  12'd0,    12'd15,   1'b1, ST_BADADDR, 12'd0},
    // free of the initial block, which is already free
    '{CMD_FREE,  12'd0,    12'd16,   1'b1, ST_DONE,    12'd0},
    // exact fit of the whole pool, then nothing is left
    '{CMD_ALLOC, 12'd4080, 12'd0,    1'b1, ST_DONE,    12'd16},
    '{CMD_ALLOC, 12'd1,    12'd0,    1'b1, ST_NOFIT,   12'd0},
    '{CMD_FREE,  12'd0,    12'd16,   1'b1, ST_DONE,    12'd0},
    // smallest grant splits the pool in two
    '{CMD_ALLOC, 12'd1,    12'd0,    1'b1, ST_DONE,    12'd16},
    '{CMD_ALLOC, 12'd4063, 12'd0,    1'b0, ST_DONE,    12'd0},
    '{CMD_FREE,  12'd0,    12'd33,   1'b0, ST_DONE,    12'd0},
    // inside a block's data, not at its start
    '{CMD_FREE,  12'd0,    12'd34,   1'b1, ST_BADADDR, 12'd0},
    '{CMD_FREE,  12'd0,    12'd16,   1'b0, ST_DONE,    12'd0},
    // double free
    '{CMD_FREE,  12'd0,    12'd16,   1'b0, ST_DONE,    12'd0},
    // leftover one byte short of a header plus data: no split
    '{CMD_ALLOC, 12'd4047, 12'd0,    1'b0, ST_DONE,    12'd0},
    '{CMD_ALLOC, 12'd1,    12'd0,    1'b0, ST_DONE,    12'd0},
    '{CMD_FREE,  12'd0,    12'd33,   1'b0, ST_DONE,    12'd0},
    // leftover just big enough: split off a one-byte block at the pool end
    '{CMD_ALLOC, 12'd4046, 12'd0,    1'b0, ST_DONE,    12'd0},
    '{CMD_ALLOC, 12'd1,    12'd0,    1'b0, ST_DONE,    12'd0},
    '{CMD_FREE,  12'd0,    12'd4095, 1'b0, ST_DONE,    12'd0},
    '{CMD_ALLOC, 12'd2,    12'd0,    1'b0, ST_DONE,    12'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [11:0] req_size, [23:12] data_offset
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [11:0] grant_offset, [15:12] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status

  worst_fit_block_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow pool: one entry per byte offset, as the block keeps it.
  bit          is_start [POOL_BYTES];
  bit          is_free  [POOL_BYTES];
  int unsigned data_len [POOL_BYTES];

  result_t     replies_due [$];   // replies owed by the block, oldest first
  int unsigned live_grants [$];   // data offsets currently allocated
  int unsigned freed_grants [$];  // recently freed offsets, for double frees
  int unsigned burst_left = 0;
  int unsigned ready_run = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  result_t     oldest;

  // Apply one item to the shadow pool and return the reply it earns.
  function automatic result_t pool_apply(cmd_t c, field_t req, field_t off);
    int unsigned cur;
    int unsigned best;
    int unsigned best_len;
    bit          found;
    result_t     r;
    r.status = ST_DONE;
    r.grant  = '0;
    cur      = 0;
    best     = 0;
    best_len = 0;
    found    = 1'b0;
    if (c == CMD_FREE) begin
      // Null is a no-op; anything but a block's data offset is rejected.
      if (off == 0)
        return r;
      if (off < HEADER_BYTES || !is_start[off - HEADER_BYTES]) begin
        r.status = ST_BADADDR;
        return r;
      end
      is_free[off - HEADER_BYTES] = 1'b1;
      return r;
    end
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    // Walk every block; keep the first of the largest free ones that fit.
    while (cur < POOL_BYTES && is_start[cur]) begin
      if (is_free[cur] && data_len[cur] >= req && data_len[cur] > best_len) begin
        best     = cur;
        best_len = data_len[cur];
        found    = 1'b1;
      end
      cur = cur + HEADER_BYTES + data_len[cur];
    end
    if (!found) begin
      r.status = ST_NOFIT;
      return r;
    end
    // Split only when the leftover holds a header and at least one byte.
    if (best_len - req >= HEADER_BYTES + 1 &&
        best + HEADER_BYTES + req < POOL_BYTES) begin
      is_start[best + HEADER_BYTES + req] = 1'b1;
      is_free[best + HEADER_BYTES + req]  = 1'b1;
      data_len[best + HEADER_BYTES + req] = best_len - req - HEADER_BYTES;
      data_len[best] = req;
    end
    is_free[best] = 1'b0;
    r.grant = field_t'(best + HEADER_BYTES);
    return r;
  endfunction

  // Keep the lists of live and freed grants in step with the replies.
  function automatic void note_outcome(cmd_t c, field_t off, result_t r);
    int hit;
    hit = -1;
    if (r.status != ST_DONE)
      return;
    if (c == CMD_ALLOC) begin
      live_grants.push_back(r.grant);
    end else if (off != 0) begin
      foreach (live_grants[i])
        if (hit < 0 && live_grants[i] == off)
          hit = i;
      if (hit >= 0)
        live_grants.delete(hit);
      freed_grants.push_back(off);
      if (freed_grants.size() > 64)
        void'(freed_grants.pop_front());
    end
  endfunction

  // Offer one item and hold it until the block takes it. Bursts of
  // back-to-back items alternate with gaps of random length, and some
  // bursts run long to give stretches with no idling at all.
  task automatic offer_item(input cmd_t c, input field_t req, input field_t off,
                            output result_t due);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 30);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {off, req};
    do @(posedge clk); while (!s_axis_tready);
    due = pool_apply(c, req, off);
  endtask

  // Receiver: long ready stretches, short ready runs and stalls, chosen at random
  // whenever the current run ends.
  always @(posedge clk) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready <= 1'b1;
          ready_run     <= $urandom_range(20, 200);
        end
        1, 2: begin
          m_axis_tready <= 1'b1;
          ready_run     <= $urandom_range(0, 7);
        end
        default: begin
          m_axis_tready <= 1'b0;
          ready_run     <= $urandom_range(0, 23);
        end
      endcase
    end
  end

  // Compare each reply the block hands over with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none owed: status %0d grant %0d", $time,
                 m_axis_tuser, m_axis_tdata[11:0]);
        mismatches++;
      end else begin
        oldest = replies_due.pop_front();
        if (m_axis_tuser != oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   oldest.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[11:0] != oldest.grant) begin
          $display("%0t: grant_offset expected %0d actual %0d", $time,
                   oldest.grant, m_axis_tdata[11:0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up once the run reaches LIMIT_CYCLES, as when the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    probe_t      row;
    result_t     due;
    cmd_t        c;
    field_t      req;
    field_t      off;
    int unsigned pick;

    // Shadow pool starts as one free block over the whole pool.
    foreach (is_start[i]) begin
      is_start[i] = 1'b0;
      is_free[i]  = 1'b0;
      data_len[i] = 0;
    end
    is_start[0] = 1'b1;
    is_free[0]  = 1'b1;
    data_len[0] = POOL_BYTES - HEADER_BYTES;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed plan; the block's clearing sweep simply holds off the first item.
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      offer_item(row.cmd, row.req, row.off, due);
      if (row.known)
        replies_due.push_back('{status: row.want_status, grant: row.want_grant});
      else
        replies_due.push_back(due);
      note_outcome(row.cmd, row.off, due);
    end

    // Random part: mostly allocates of small sizes and frees of live grants,
    // so the pool fills, fragments and gets walked end to end; the rest is
    // null frees, stray addresses, double frees, full-range and zero-size requests.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      c    = CMD_ALLOC;
      req  = field_t'($urandom);
      off  = field_t'($urandom);
      if (pick < 4) begin
        c   = CMD_FREE;
        off = '0;
      end else if (pick < 8) begin
        c = CMD_FREE;
      end else if (pick < 10 && live_grants.size() != 0) begin
        c   = CMD_FREE;
        off = field_t'(live_grants[$urandom_range(0, live_grants.size() - 1)] +
                       $urandom_range(1, 20));
      end else if (pick < 12 && freed_grants.size() != 0) begin
        c   = CMD_FREE;
        off = field_t'(freed_grants[$urandom_range(0, freed_grants.size() - 1)]);
      end else if (pick < 15) begin
        // keep the full-range request
      end else if (pick < 16) begin
        req = '0;
      end else if (pick < 58 || live_grants.size() == 0) begin
        req = ($urandom_range(0, 7) == 0) ? field_t'($urandom_range(1, 600))
                                          : field_t'($urandom_range(1, 48));
      end else begin
        c   = CMD_FREE;
        off = field_t'(live_grants[$urandom_range(0, live_grants.size() - 1)]);
      end
      offer_item(c, req, off, due);
      replies_due.push_back(due);
      note_outcome(c, off, due);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch a while longer for stray replies.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/wfba_pkg.sv
sv/wfba_table.sv
sv/wfba_ctrl.sv
sv/worst_fit_block_allocator.sv
sim/tb_worst_fit_block_allocator.sv
